/* hw/rtl/fpt_pkg.sv */
// Shared constants, register indexes and types for the frame pacing timer.
// Used by every module under hw/rtl; depends on nothing.
package fpt_pkg;

    localparam int TS_W       = 63;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int DELTA_W    = 32;
    localparam int OVER_LIMIT = 8;
    localparam int CLAMP_W    = CFG_W + $clog2(OVER_LIMIT);
    localparam int ACC_W      = 36;
    localparam int ACC_SUM_W  = ACC_W + 1;
    localparam int COUNT_W    = 4;

    localparam int HISTORY_DEPTH_DEF  = 4;
    localparam int SNAP_MULTIPLES_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_PERIOD    = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_PERIOD_RST   = 32'd16666;
    localparam logic [CFG_W-1:0] SNAP_TOLERANCE_RST = 32'd200;
    localparam logic [CFG_W-1:0] SNAP_PERIOD_RST    = 32'd16666;

    // Load strobes, one per pipeline stage: a valid beat moves into that stage.
    typedef struct packed {
        logic delta;
        logic snap;
        logic mul;
        logic div;
        logic hist;
        logic result;
    } stage_load_t;

    // Width of the largest snap multiple, SNAP_MULTIPLES times a 32-bit period.
    function automatic int snap_mult_w(input int multiples);
        return CFG_W + $clog2(multiples + 1);
    endfunction

endpackage

/* hw/rtl/fpt_cfg_regs.sv */
// Configuration registers of the frame pacing timer, kept as tables of multiples.
// Depends on fpt_pkg.
module fpt_cfg_regs #(
    parameter int SNAP_MULTIPLES = fpt_pkg::SNAP_MULTIPLES_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic [fpt_pkg::CFG_IDX_W-1:0]                 cfg_index,
    input  logic [fpt_pkg::CFG_W-1:0]                     cfg_data,
    output logic [fpt_pkg::CLAMP_W-1:0]                   fp_mult [fpt_pkg::OVER_LIMIT],
    output logic [fpt_pkg::CFG_W-1:0]                     snap_tol,
    output logic [fpt_pkg::snap_mult_w(SNAP_MULTIPLES)-1:0] snap_mult [SNAP_MULTIPLES]
);

    localparam int MULT_W = fpt_pkg::snap_mult_w(SNAP_MULTIPLES);

    // Entry j holds (j+1) times the written period, so later stages only compare.
    logic [fpt_pkg::CLAMP_W-1:0] fp_mult_reg   [fpt_pkg::OVER_LIMIT];
    logic [fpt_pkg::CLAMP_W-1:0] fp_mult_next  [fpt_pkg::OVER_LIMIT];
    logic [MULT_W-1:0]           snap_mult_reg [SNAP_MULTIPLES];
    logic [MULT_W-1:0]           snap_mult_next[SNAP_MULTIPLES];
    logic [fpt_pkg::CFG_W-1:0]   snap_tol_reg;
    logic [fpt_pkg::CFG_W-1:0]   snap_tol_next;

    always_comb
    begin
        fp_mult_next   = fp_mult_reg;
        snap_mult_next = snap_mult_reg;
        snap_tol_next  = snap_tol_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                fpt_pkg::CFG_FRAME_PERIOD:
                begin
                    for (int j = 0; j < fpt_pkg::OVER_LIMIT; j++)
                    begin
                        fp_mult_next[j] = fpt_pkg::CLAMP_W'(cfg_data)
                                          * fpt_pkg::CLAMP_W'(j + 1);
                    end
                end
                fpt_pkg::CFG_SNAP_TOLERANCE:
                begin
                    snap_tol_next = cfg_data;
                end
                fpt_pkg::CFG_SNAP_PERIOD:
                begin
                    for (int j = 0; j < SNAP_MULTIPLES; j++)
                    begin
                        snap_mult_next[j] = MULT_W'(cfg_data) * MULT_W'(j + 1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < fpt_pkg::OVER_LIMIT; j++)
            begin
                fp_mult_reg[j] <= fpt_pkg::CLAMP_W'(fpt_pkg::FRAME_PERIOD_RST)
                                  * fpt_pkg::CLAMP_W'(j + 1);
            end
            for (int j = 0; j < SNAP_MULTIPLES; j++)
            begin
                snap_mult_reg[j] <= MULT_W'(fpt_pkg::SNAP_PERIOD_RST) * MULT_W'(j + 1);
            end
            snap_tol_reg <= fpt_pkg::SNAP_TOLERANCE_RST;
        end
        else
        begin
            fp_mult_reg   <= fp_mult_next;
            snap_mult_reg <= snap_mult_next;
            snap_tol_reg  <= snap_tol_next;
        end
    end

    assign fp_mult   = fp_mult_reg;
    assign snap_mult = snap_mult_reg;
    assign snap_tol  = snap_tol_reg;

endmodule

/* hw/rtl/fpt_delta.sv */
// Delta stages: timestamp difference with clamping, then snapping to refresh multiples.
// Depends on fpt_pkg.
module fpt_delta #(
    parameter int SNAP_MULTIPLES = fpt_pkg::SNAP_MULTIPLES_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  fpt_pkg::stage_load_t                          load,
    input  logic [fpt_pkg::TS_W-1:0]                      timestamp,
    input  logic [fpt_pkg::CLAMP_W-1:0]                   fp_mult [fpt_pkg::OVER_LIMIT],
    input  logic [fpt_pkg::CFG_W-1:0]                     snap_tol,
    input  logic [fpt_pkg::snap_mult_w(SNAP_MULTIPLES)-1:0] snap_mult [SNAP_MULTIPLES],
    output logic [fpt_pkg::DELTA_W-1:0]                   delta
);

    localparam int MULT_W = fpt_pkg::snap_mult_w(SNAP_MULTIPLES);
    localparam int CMP_W  = (MULT_W > fpt_pkg::CLAMP_W) ? MULT_W : fpt_pkg::CLAMP_W;

    logic [fpt_pkg::TS_W-1:0]    last_ts_reg;
    logic [fpt_pkg::TS_W-1:0]    diff;
    logic [fpt_pkg::CLAMP_W-1:0] clamp_reg;
    logic [fpt_pkg::CLAMP_W-1:0] clamp_next;
    logic [fpt_pkg::DELTA_W-1:0] snap_reg;
    logic [fpt_pkg::DELTA_W-1:0] snap_next;
    logic [CMP_W-1:0]            d_ext;
    logic [CMP_W-1:0]            m_ext;
    logic [CMP_W-1:0]            gap;
    logic [CMP_W-1:0]            pick;
    logic                        found;

    // The difference wraps at 63 bits; its top bit marks a counter that went backwards.
    always_comb
    begin
        diff = timestamp - last_ts_reg;
        priority if (diff[fpt_pkg::TS_W-1])
        begin
            clamp_next = '0;
        end
        else if (diff > fpt_pkg::TS_W'(fp_mult[fpt_pkg::OVER_LIMIT-1]))
        begin
            clamp_next = fp_mult[0];
        end
        else
        begin
            clamp_next = diff[fpt_pkg::CLAMP_W-1:0];
        end
    end

    // The lowest multiple within tolerance wins.
    always_comb
    begin
        d_ext = CMP_W'(clamp_reg);
        pick  = d_ext;
        found = 1'b0;
        m_ext = '0;
        gap   = '0;
        for (int k = 0; k < SNAP_MULTIPLES; k++)
        begin
            m_ext = CMP_W'(snap_mult[k]);
            gap   = (d_ext >= m_ext) ? (d_ext - m_ext) : (m_ext - d_ext);
            if (!found && (gap < CMP_W'(snap_tol)))
            begin
                pick  = m_ext;
                found = 1'b1;
            end
        end
        if (pick[CMP_W-1:fpt_pkg::DELTA_W] != '0)
        begin
            snap_next = '1;
        end
        else
        begin
            snap_next = pick[fpt_pkg::DELTA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ts_reg <= '0;
        end
        else if (load.delta)
        begin
            last_ts_reg <= timestamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.delta)
        begin
            clamp_reg <= clamp_next;
        end
        if (load.snap)
        begin
            snap_reg <= snap_next;
        end
    end

    assign delta = snap_reg;

endmodule

/* hw/rtl/fpt_average.sv */
// History stages: split each delta into quotient and remainder by the depth,
// then average over the history with the remainder carried. Depends on fpt_pkg.
module fpt_average #(
    parameter int HISTORY_DEPTH = fpt_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fpt_pkg::stage_load_t        load,
    input  logic [fpt_pkg::DELTA_W-1:0] delta,
    output logic [fpt_pkg::DELTA_W-1:0] average
);

    localparam int R_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int REM_SUM_W  = R_W + 1;
    localparam int RS_W       = $clog2(HISTORY_DEPTH * HISTORY_DEPTH + 1);
    localparam int AVG_W      = fpt_pkg::DELTA_W + 1;
    localparam logic [63:0] RECIP_WIDE = 64'hFFFF_FFFF / 64'(HISTORY_DEPTH);
    localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
    localparam logic [31:0] DEPTH32    = 32'(HISTORY_DEPTH);
    localparam logic [31:0] HIST_Q_RST = fpt_pkg::FRAME_PERIOD_RST / DEPTH32;
    localparam logic [R_W-1:0] HIST_R_RST = R_W'(fpt_pkg::FRAME_PERIOD_RST % DEPTH32);

    logic [63:0]                 prod;
    logic [31:0]                 q_est_reg;
    logic [fpt_pkg::DELTA_W-1:0] d_mul_reg;
    logic [31:0]                 q_back;
    logic [31:0]                 r_raw;
    logic [31:0]                 q_div_next;
    logic [R_W-1:0]              r_div_next;
    logic [31:0]                 q_div_reg;
    logic [R_W-1:0]              r_div_reg;

    logic [31:0]          hq_reg  [HISTORY_DEPTH];
    logic [31:0]          hq_next [HISTORY_DEPTH];
    logic [R_W-1:0]       hr_reg  [HISTORY_DEPTH];
    logic [R_W-1:0]       hr_next [HISTORY_DEPTH];
    logic [R_W-1:0]       rem_reg;
    logic [R_W-1:0]       rem_next;
    logic [31:0]          sum_q;
    logic [RS_W-1:0]      sum_r;
    logic [R_W-1:0]       q_small;
    logic [R_W-1:0]       r_small;
    logic [REM_SUM_W-1:0] rem_sum;
    logic                 carry;
    logic [AVG_W-1:0]     avg_wide;
    logic [fpt_pkg::DELTA_W-1:0] avg_next;
    logic [fpt_pkg::DELTA_W-1:0] avg_reg;

    // The reciprocal estimate is low by at most one, fixed by one compare.
    assign prod = 64'(delta) * 64'(RECIP);

    always_comb
    begin
        q_back = q_est_reg * DEPTH32;
        r_raw  = d_mul_reg - q_back;
        if (r_raw >= DEPTH32)
        begin
            q_div_next = q_est_reg + 32'd1;
            r_div_next = R_W'(r_raw - DEPTH32);
        end
        else
        begin
            q_div_next = q_est_reg;
            r_div_next = R_W'(r_raw);
        end
    end

    // Sum of entries over the depth equals the quotient sum plus the remainder sum
    // over the depth; the remainder sum is small enough for a row of compares.
    always_comb
    begin
        for (int i = 0; i < HISTORY_DEPTH - 1; i++)
        begin
            hq_next[i] = hq_reg[i + 1];
            hr_next[i] = hr_reg[i + 1];
        end
        hq_next[HISTORY_DEPTH-1] = q_div_reg;
        hr_next[HISTORY_DEPTH-1] = r_div_reg;

        sum_q = '0;
        sum_r = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            sum_q = sum_q + hq_next[i];
            sum_r = sum_r + RS_W'(hr_next[i]);
        end

        q_small = '0;
        r_small = R_W'(sum_r);
        for (int j = 1; j < HISTORY_DEPTH; j++)
        begin
            if (sum_r >= RS_W'(j * HISTORY_DEPTH))
            begin
                q_small = R_W'(j);
                r_small = R_W'(sum_r - RS_W'(j * HISTORY_DEPTH));
            end
        end

        rem_sum  = REM_SUM_W'(rem_reg) + REM_SUM_W'(r_small);
        carry    = (rem_sum >= REM_SUM_W'(HISTORY_DEPTH));
        rem_next = carry ? R_W'(rem_sum - REM_SUM_W'(HISTORY_DEPTH)) : R_W'(rem_sum);
        avg_wide = AVG_W'(sum_q) + AVG_W'(q_small) + AVG_W'(carry);
        avg_next = avg_wide[AVG_W-1] ? '1 : avg_wide[fpt_pkg::DELTA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hq_reg[i] <= HIST_Q_RST;
                hr_reg[i] <= HIST_R_RST;
            end
            rem_reg <= '0;
        end
        else if (load.hist)
        begin
            hq_reg  <= hq_next;
            hr_reg  <= hr_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.mul)
        begin
            q_est_reg <= prod[63:32];
            d_mul_reg <= delta;
        end
        if (load.div)
        begin
            q_div_reg <= q_div_next;
            r_div_reg <= r_div_next;
        end
        if (load.hist)
        begin
            avg_reg <= avg_next;
        end
    end

    assign average = avg_reg;

endmodule

/* hw/rtl/fpt_accum.sv */
// Tick accumulator: adds the average, resyncs on overflow and drains whole
// frame periods into the update count. Depends on fpt_pkg.
module fpt_accum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fpt_pkg::stage_load_t        load,
    input  logic [fpt_pkg::DELTA_W-1:0] average,
    input  logic [fpt_pkg::CLAMP_W-1:0] fp_mult [fpt_pkg::OVER_LIMIT],
    output logic [fpt_pkg::COUNT_W-1:0] update_count,
    output logic [fpt_pkg::DELTA_W-1:0] smoothed_delta,
    output logic                        resynced
);

    logic [fpt_pkg::ACC_W-1:0]     acc_reg;
    logic [fpt_pkg::ACC_W-1:0]     acc_next;
    logic [fpt_pkg::ACC_SUM_W-1:0] acc_sum;
    logic [fpt_pkg::CLAMP_W-1:0]   acc_kept;
    logic [fpt_pkg::CLAMP_W-1:0]   drain;
    logic                          resync;
    logic [fpt_pkg::COUNT_W-1:0]   count_next;
    logic [fpt_pkg::DELTA_W-1:0]   smooth_next;
    logic [fpt_pkg::COUNT_W-1:0]   count_reg;
    logic [fpt_pkg::DELTA_W-1:0]   smooth_reg;
    logic                          resync_reg;

    // Without a resync the sum is at most eight periods, so it fits the clamp width.
    // The count is the largest multiple of the period not above the kept value.
    always_comb
    begin
        acc_sum  = fpt_pkg::ACC_SUM_W'(acc_reg) + fpt_pkg::ACC_SUM_W'(average);
        resync   = (acc_sum > fpt_pkg::ACC_SUM_W'(fp_mult[fpt_pkg::OVER_LIMIT-1]));
        acc_kept = resync ? '0 : acc_sum[fpt_pkg::CLAMP_W-1:0];
        count_next = '0;
        drain      = '0;
        if (fp_mult[0] != '0)
        begin
            for (int k = 0; k < fpt_pkg::OVER_LIMIT; k++)
            begin
                if (acc_kept >= fp_mult[k])
                begin
                    count_next = fpt_pkg::COUNT_W'(k + 1);
                    drain      = fp_mult[k];
                end
            end
        end
        acc_next    = fpt_pkg::ACC_W'(acc_kept - drain);
        smooth_next = resync ? fp_mult[0][fpt_pkg::DELTA_W-1:0] : average;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (load.result)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.result)
        begin
            count_reg  <= count_next;
            smooth_reg <= smooth_next;
            resync_reg <= resync;
        end
    end

    assign update_count   = count_reg;
    assign smoothed_delta = smooth_reg;
    assign resynced       = resync_reg;

endmodule

/* hw/rtl/frame_pacing_timer.sv */
// Frame pacing timer top level: handshake pipeline around the delta, average
// and accumulator stages. Depends on fpt_pkg and all fpt_* modules.
//
// Usage: each input beat carries one 63-bit free-running counter timestamp,
// normally one per display frame. Each beat yields exactly one result beat with
// the number of fixed updates due, the smoothed frame delta and a resync flag.
// Both channels use valid/ready; configuration is a plain write port
// (cfg_we, cfg_index, cfg_data), to be used only while the block holds no beat;
// the block itself does not enforce this. Throughput is one beat per cycle,
// while out_ready holds; the accumulator stage (add, overflow compare and
// quotient select feeding back into the accumulator) sets the clock.
// Reset loads the default registers, clears the last timestamp, remainder and
// accumulator, and fills the delta history with the default frame period.
// When the receiver stalls, beats collect in the six stage registers, each
// stage closing up behind the one ahead; in_ready drops only once all are full.
// History, remainder and accumulator advance as a beat enters their stage.
module frame_pacing_timer #(
    parameter int HISTORY_DEPTH  = fpt_pkg::HISTORY_DEPTH_DEF,
    parameter int SNAP_MULTIPLES = fpt_pkg::SNAP_MULTIPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fpt_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fpt_pkg::TS_W-1:0]      timestamp,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fpt_pkg::COUNT_W-1:0]   update_count,
    output logic [fpt_pkg::DELTA_W-1:0]   smoothed_delta,
    output logic                          resynced
);

    localparam int STAGES = 6;
    localparam int MULT_W = fpt_pkg::snap_mult_w(SNAP_MULTIPLES);

    logic [fpt_pkg::CLAMP_W-1:0] fp_mult   [fpt_pkg::OVER_LIMIT];
    logic [MULT_W-1:0]           snap_mult [SNAP_MULTIPLES];
    logic [fpt_pkg::CFG_W-1:0]   snap_tol;
    logic [fpt_pkg::DELTA_W-1:0] delta;
    logic [fpt_pkg::DELTA_W-1:0] average;

    logic [STAGES-1:0]    stage_valid_reg;
    logic [STAGES-1:0]    stage_valid_next;
    logic [STAGES-1:0]    stage_ready;
    logic [STAGES-1:0]    stage_fill;
    fpt_pkg::stage_load_t load;

    // A stage takes a beat when it is empty or its own beat moves on.
    always_comb
    begin
        stage_ready[STAGES-1] = !stage_valid_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            stage_ready[i] = !stage_valid_reg[i] || stage_ready[i + 1];
        end
        stage_fill = {stage_valid_reg[STAGES-2:0], in_valid} & stage_ready;
        for (int i = 0; i < STAGES; i++)
        begin
            stage_valid_next[i] = stage_ready[i] ? stage_fill[i] : stage_valid_reg[i];
        end
    end

    assign load.delta  = stage_fill[0];
    assign load.snap   = stage_fill[1];
    assign load.mul    = stage_fill[2];
    assign load.div    = stage_fill[3];
    assign load.hist   = stage_fill[4];
    assign load.result = stage_fill[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = stage_valid_reg[STAGES-1];

    fpt_cfg_regs #(
        .SNAP_MULTIPLES (SNAP_MULTIPLES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fp_mult   (fp_mult),
        .snap_tol  (snap_tol),
        .snap_mult (snap_mult)
    );

    fpt_delta #(
        .SNAP_MULTIPLES (SNAP_MULTIPLES)
    ) u_delta (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .timestamp (timestamp),
        .fp_mult   (fp_mult),
        .snap_tol  (snap_tol),
        .snap_mult (snap_mult),
        .delta     (delta)
    );

    fpt_average #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_average (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .delta   (delta),
        .average (average)
    );

    fpt_accum u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .average        (average),
        .fp_mult        (fp_mult),
        .update_count   (update_count),
        .smoothed_delta (smoothed_delta),
        .resynced       (resynced)
    );

    // An empty output stage means every stage behind it can take a beat.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while the output stage is empty");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (update_count <= fpt_pkg::COUNT_W'(fpt_pkg::OVER_LIMIT)))
        else $error("update count above the overflow limit");

    a_resync_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && resynced) |->
            ((smoothed_delta == fp_mult[0][fpt_pkg::DELTA_W-1:0]) && (update_count == '0)))
        else $error("resync beat without frame period and zero count");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for frame_pacing_timer: timestamp beats in, pacing results out.
// Holds its own cycle-free predictor of delta cleanup, averaging and accumulation.
// Depends on fpt_pkg and the frame_pacing_timer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpt_pkg::*;

    localparam int HIST_N         = HISTORY_DEPTH_DEF;
    localparam int SNAP_N         = SNAP_MULTIPLES_DEF;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 70;
    localparam int REPORT_CAP     = 40;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [DELTA_W-1:0] smooth;
        logic               resync;
    } frame_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_PERIOD;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [TS_W-1:0]      timestamp = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [COUNT_W-1:0]   update_count;
    logic [DELTA_W-1:0]   smoothed_delta;
    logic                 resynced;

    frame_pacing_timer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .timestamp      (timestamp),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .update_count   (update_count),
        .smoothed_delta (smoothed_delta),
        .resynced       (resynced)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state, kept in step with the block's registers.
    logic [CFG_W-1:0]   mdl_fp;
    logic [CFG_W-1:0]   mdl_tol;
    logic [CFG_W-1:0]   mdl_sp;
    logic [TS_W-1:0]    prev_stamp;
    logic [DELTA_W-1:0] delta_hist [HIST_N];
    logic [63:0]        carry_rem;
    logic [63:0]        tick_acc;

    frame_result_t expected_frames [$];

    int stamps_sent   = 0;
    int results_seen  = 0;
    int resyncs_seen  = 0;
    int settings_used = 0;
    int mismatches    = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;

    // Clamp a raw frame delta and pull it onto the lowest snap multiple within tolerance.
    function automatic logic [DELTA_W-1:0] snapped_delta(input logic [TS_W-1:0] ts);
        logic [TS_W-1:0] diff;
        logic [63:0]     lim;
        logic [63:0]     d;
        logic [63:0]     m;
        logic [63:0]     offset;
        diff = ts - prev_stamp;
        lim = {32'd0, mdl_fp} * OVER_LIMIT;
        if (diff[TS_W-1])
            d = '0;
        else if ({1'b0, diff} > lim)
            d = {32'd0, mdl_fp};
        else
            d = {1'b0, diff};
        for (int k = 1; k <= SNAP_N; k++)
        begin
            m = {32'd0, mdl_sp} * k;
            offset = (d >= m) ? d - m : m - d;
            if (offset < {32'd0, mdl_tol})
            begin
                d = m;
                break;
            end
        end
        return (d > 64'hFFFF_FFFF) ? '1 : d[DELTA_W-1:0];
    endfunction

    function automatic frame_result_t predict_frame(input logic [TS_W-1:0] ts);
        logic [DELTA_W-1:0] d;
        logic [63:0]        sum;
        logic [63:0]        avg;
        logic [63:0]        lim;
        frame_result_t      r;
        d = snapped_delta(ts);
        prev_stamp = ts;
        for (int i = 0; i < HIST_N - 1; i++)
            delta_hist[i] = delta_hist[i + 1];
        delta_hist[HIST_N - 1] = d;
        sum = '0;
        for (int i = 0; i < HIST_N; i++)
            sum += delta_hist[i];
        avg = sum / HIST_N;
        carry_rem += sum % HIST_N;
        avg += carry_rem / HIST_N;
        carry_rem %= HIST_N;
        if (avg > 64'hFFFF_FFFF)
            avg = 64'hFFFF_FFFF;
        r.smooth = avg[DELTA_W-1:0];
        r.resync = 1'b0;
        tick_acc += avg;
        lim = {32'd0, mdl_fp} * OVER_LIMIT;
        if (tick_acc > lim)
        begin
            r.resync = 1'b1;
            tick_acc = '0;
            r.smooth = mdl_fp;
        end
        r.count = '0;
        if (mdl_fp != 0)
        begin
            r.count = COUNT_W'(tick_acc / {32'd0, mdl_fp});
            tick_acc = tick_acc % {32'd0, mdl_fp};
        end
        return r;
    endfunction

    // Mostly frame-like steps near vsync multiples, with clamps, rewinds and noise mixed in.
    function automatic logic [TS_W-1:0] next_stamp();
        logic [63:0] step;
        logic [63:0] jit;
        logic [63:0] raw;
        int          pick;
        int          k;
        pick = $urandom_range(0, 99);
        k = $urandom_range(1, SNAP_N + 1);
        raw = {$urandom, $urandom};
        if (pick < 70)
        begin
            jit = raw % ({32'd0, mdl_tol} + 64'd9);
            step = {32'd0, mdl_sp} * k;
            step = $urandom_range(0, 1) ? step + jit : step - jit;
            return prev_stamp + step[TS_W-1:0];
        end
        else if (pick < 80)
        begin
            step = {32'd0, mdl_fp} * k + $urandom_range(0, 2);
            return prev_stamp + step[TS_W-1:0] - 1'b1;
        end
        else if (pick < 90)
            return prev_stamp - TS_W'($urandom_range(1, 100000));
        else
            return raw[TS_W-1:0];
    endfunction

    task automatic send_stamp(input logic [TS_W-1:0] ts);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        timestamp <= ts;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_frames.push_back(predict_frame(ts));
        stamps_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_frames.size() != 0);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] fp, input logic [CFG_W-1:0] tol,
                              input logic [CFG_W-1:0] sp);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_FRAME_PERIOD;
        cfg_data <= fp;
        @(posedge clk);
        cfg_index <= CFG_SNAP_TOLERANCE;
        cfg_data <= tol;
        @(posedge clk);
        cfg_index <= CFG_SNAP_PERIOD;
        cfg_data <= sp;
        @(posedge clk);
        cfg_we <= 1'b0;
        mdl_fp = fp;
        mdl_tol = tol;
        mdl_sp = sp;
        settings_used++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // Reset defaults: exact and near vsync frames, tolerance edges, clamp, rewind, wrap.
    task automatic test_nominal_frames();
        send_stamp('0);
        send_stamp(prev_stamp + 63'd16666);
        send_stamp(prev_stamp + 63'd16816);
        send_stamp(prev_stamp + 63'd16866);
        send_stamp(prev_stamp + 63'd16467);
        send_stamp(prev_stamp + 63'd33342);
        send_stamp(prev_stamp + 63'd500);
        send_stamp(prev_stamp + 63'd133329);
        send_stamp(prev_stamp + 63'd133328);
        send_stamp(prev_stamp);
        send_stamp(prev_stamp - 63'd1000);
        send_stamp('1);
        send_stamp('0);
        send_stamp({1'b0, {(TS_W-1){1'b1}}});
    endtask

    // Deltas beyond 32 bits, both unsnapped and snapped, fill the history with saturation.
    task automatic test_wide_delta();
        set_config('1, 32'd16, '1);
        send_stamp(prev_stamp + 63'h4_0000_0064);
        send_stamp(prev_stamp + 63'h2_0000_0001);
        send_stamp(prev_stamp + 63'h4_0000_0000);
        send_stamp(prev_stamp + 63'h2_0000_03E8);
        send_stamp(prev_stamp + 63'h4_0000_0064);
        send_stamp(prev_stamp + 63'd5);
    endtask

    // Zero frame period never drains the accumulator; zero snap period snaps small deltas to 0.
    task automatic test_zero_periods();
        set_config('0, 32'd300, '0);
        send_stamp(prev_stamp);
        send_stamp(prev_stamp + 63'd100);
        send_stamp(prev_stamp + 63'd299);
        send_stamp(prev_stamp + 63'd1000);
        set_config(32'd5000, 32'd250, '0);
        send_stamp(prev_stamp + 63'd100);
        send_stamp(prev_stamp + 63'd400);
        send_stamp(prev_stamp + 63'd4000);
    endtask

    task automatic test_random_frames();
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: set_config(32'd16666, 32'd200, 32'd16666);
                1: set_config(32'd16666, 32'd500, 32'd8333);
                2: set_config(32'd1000, 32'd0, 32'd1);
                3: set_config($urandom_range(1, 1 << 20), $urandom_range(0, 4096),
                              $urandom_range(1, 1 << 20));
                4: set_config('1, '1, '1);
                5: set_config(32'd1, $urandom_range(0, 64), $urandom_range(1, 64));
                default: set_config($urandom, $urandom, $urandom);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_stamp(next_stamp());
        end
    endtask

    // The sender holds off until the block has returned every result, then resumes.
    task automatic test_drain_between_frames();
        set_config(32'd16666, 32'd200, 32'd16666);
        for (int n = 0; n < 20; n++)
        begin
            send_stamp(next_stamp());
            if (n % 5 == 4)
                wait_drained();
        end
    endtask

    initial
    begin
        mdl_fp = FRAME_PERIOD_RST;
        mdl_tol = SNAP_TOLERANCE_RST;
        mdl_sp = SNAP_PERIOD_RST;
        prev_stamp = '0;
        for (int i = 0; i < HIST_N; i++)
            delta_hist[i] = FRAME_PERIOD_RST;
        carry_rem = '0;
        tick_acc = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_nominal_frames();
        test_wide_delta();
        test_zero_periods();
        test_random_frames();
        test_drain_between_frames();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d timestamps and %0d results under %0d register settings,",
                 stamps_sent, results_seen, settings_used + 1);
        $display("with %0d accumulator resyncs and %0d mismatches.", resyncs_seen, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side: compare each beat and pick the next ready from a changing stall pattern.
    int unsigned rx_cycle = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_stall = 0;

    always @(posedge clk)
    begin
        frame_result_t want;
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (expected_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t ns: expected no result, got count %0d delta 0x%0h resync %0b",
                             $time, update_count, smoothed_delta, resynced);
            end
            else
            begin
                want = expected_frames.pop_front();
                if (want.resync)
                    resyncs_seen++;
                check_field("update_count", 32'(want.count), 32'(update_count));
                check_field("smoothed_delta", want.smooth, smoothed_delta);
                check_field("resynced", 32'(want.resync), 32'(resynced));
            end
        end
        rx_cycle++;
        if (rx_cycle % 97 == 0)
            rx_mode = $urandom_range(0, 3);
        if (rx_stall != 0)
        begin
            rx_stall--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= (rx_cycle % 4 == 0);
                default:
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        rx_stall = $urandom_range(1, 40);
                        out_ready <= 1'b0;
                    end
                    else
                        out_ready <= 1'b1;
                end
            endcase
        end
    end

    // A run that stops moving beats on either channel for too long has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no beat moved for %0d cycles at %0t ns", idle_cycles, $time);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule

/* frame_pacing_timer.f */
hw/rtl/fpt_pkg.sv
hw/rtl/fpt_cfg_regs.sv
hw/rtl/fpt_delta.sv
hw/rtl/fpt_average.sv
hw/rtl/fpt_accum.sv
hw/rtl/frame_pacing_timer.sv
bench/tb_top.sv
